FILE: rtl/core/key_debounce_short_long_press_assert.svh
// Assertion macros for the key debounce block and its port checker.
// No dependencies; include by bare file name.
`ifndef KEY_DEBOUNCE_SHORT_LONG_PRESS_ASSERT_SVH
`define KEY_DEBOUNCE_SHORT_LONG_PRESS_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define KDSL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kdsl: implication check failed");

// Next-cycle implication, off while reset is held.
`define KDSL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kdsl: next-cycle check failed");

// Next-cycle implication that also holds through reset.
`define KDSL_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("kdsl: reset check failed");

`endif

FILE: rtl/core/kdsl_pkg.sv
// Shared types and constants for the key debounce short/long press block.
// No dependencies.
package kdsl_pkg;

    localparam int NUM_KEYS_DEF = 4;
    localparam int PIN_W        = 4;
    localparam int CNT_W        = 8;
    localparam int IDX_W        = 8;
    localparam int OP_W         = 2;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 16;
    localparam int APB_AW       = 4;
    localparam int APB_DW       = 32;

    localparam logic [CNT_W-1:0] CNT_MAX         = '1;
    localparam logic [CNT_W-1:0] DEBOUNCE_RESET  = 8'd2;
    localparam logic [CNT_W-1:0] SHORT_RESET     = 8'd10;
    localparam logic [CNT_W-1:0] LONG_RESET      = 8'd100;

    typedef enum logic [1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_SHORT    = 2'd1,
        REG_LONG     = 2'd2
    } t_reg;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_QSHORT = 2'd1,
        OP_QLONG  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_PRESSED  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [CNT_W-1:0] debounce_ticks;
        logic [CNT_W-1:0] short_ticks;
        logic [CNT_W-1:0] long_ticks;
    } t_cfg;

    typedef struct packed {
        logic step;
        logic down;
        logic clr_short;
        logic clr_long;
    } t_key_ctrl;

    typedef struct packed {
        logic short_flag;
        logic long_flag;
        logic nxt_short;
        logic nxt_long;
    } t_key_stat;

endpackage

FILE: rtl/core/kdsl_cfg_regs.sv
// Configuration register file behind the APB-style port.
// Depends on kdsl_pkg.
module kdsl_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [kdsl_pkg::APB_AW-1:0] paddr,
    input  logic [kdsl_pkg::APB_DW-1:0] pwdata,
    output logic [kdsl_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output kdsl_pkg::t_cfg             o_cfg
);
    import kdsl_pkg::*;

    logic [CNT_W-1:0] r_debounce, r_short, r_long;
    logic             wr_en;
    logic [1:0]       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
            r_short    <= SHORT_RESET;
            r_long     <= LONG_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_DEBOUNCE: r_debounce <= pwdata[CNT_W-1:0];
                REG_SHORT:    r_short    <= pwdata[CNT_W-1:0];
                REG_LONG:     r_long     <= pwdata[CNT_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            REG_DEBOUNCE: prdata = APB_DW'(r_debounce);
            REG_SHORT:    prdata = APB_DW'(r_short);
            REG_LONG:     prdata = APB_DW'(r_long);
            default:      prdata = '0;
        endcase
    end

    assign o_cfg.debounce_ticks = r_debounce;
    assign o_cfg.short_ticks    = r_short;
    assign o_cfg.long_ticks     = r_long;

endmodule

FILE: rtl/core/kdsl_key_cell.sv
// One key: idle/debounce/pressed sequencer, hold counter and press flags.
// Depends on kdsl_pkg.
module kdsl_key_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kdsl_pkg::t_cfg      i_cfg,
    input  kdsl_pkg::t_key_ctrl i_ctrl,
    output kdsl_pkg::t_key_stat o_stat
);
    import kdsl_pkg::*;

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_deb, n_deb;
    logic [CNT_W-1:0] r_hold, n_hold;
    logic             r_rep, n_rep;
    logic             r_sf, n_sf;
    logic             r_lf, n_lf;
    logic [CNT_W-1:0] deb_inc, hold_inc;

    assign deb_inc  = (r_deb != CNT_MAX) ? r_deb + 1'b1 : r_deb;
    assign hold_inc = r_hold + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_deb   <= '0;
            r_hold  <= '0;
            r_rep   <= 1'b0;
            r_sf    <= 1'b0;
            r_lf    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_deb   <= n_deb;
            r_hold  <= n_hold;
            r_rep   <= n_rep;
            r_sf    <= n_sf;
            r_lf    <= n_lf;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_deb   = r_deb;
        n_hold  = r_hold;
        n_rep   = r_rep;
        n_sf    = r_sf;
        n_lf    = r_lf;
        if (i_ctrl.step) begin
            unique case (r_phase)
                PH_DEBOUNCE: begin
                    if (i_ctrl.down) begin
                        n_deb = deb_inc;
                        if (deb_inc > i_cfg.debounce_ticks) begin
                            n_phase = PH_PRESSED;
                            n_hold  = '0;
                        end
                    end else begin
                        n_phase = PH_IDLE;
                        n_deb   = '0;
                    end
                end
                PH_PRESSED: begin
                    if (i_ctrl.down) begin
                        // saturated count latches nothing further
                        if (r_hold != CNT_MAX) begin
                            n_hold = hold_inc;
                            if (hold_inc == i_cfg.long_ticks) begin
                                n_lf  = 1'b1;
                                n_rep = 1'b1;
                            end else if (hold_inc == i_cfg.short_ticks && !r_rep) begin
                                n_sf  = 1'b1;
                                n_rep = 1'b1;
                            end
                        end
                    end else begin
                        n_phase = PH_IDLE;
                        n_deb   = '0;
                        n_hold  = '0;
                        n_rep   = 1'b0;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    if (i_ctrl.down) begin
                        n_phase = PH_DEBOUNCE;
                        n_deb   = '0;
                        n_rep   = 1'b0;
                    end
                end
            endcase
        end
        if (i_ctrl.clr_short) begin
            n_sf = 1'b0;
        end
        if (i_ctrl.clr_long) begin
            n_lf = 1'b0;
        end
    end

    assign o_stat.short_flag = r_sf;
    assign o_stat.long_flag  = r_lf;
    assign o_stat.nxt_short  = n_sf;
    assign o_stat.nxt_long   = n_lf;

endmodule

FILE: rtl/core/key_debounce_short_long_press.sv
// Key debounce with short/long press detection, stream in, stream out.
// Registers from input word accepted to result word valid: input register, then result register.
// One word per cycle unless the output stalls; the single key-state update stage sets it.
// Reset (i_rst_n low, synchronous): keys idle, counts and flags cleared,
// pipeline empty, limits back to debounce 2, short 10, long 100.
// Depends on kdsl_pkg, kdsl_cfg_regs and kdsl_key_cell.
module key_debounce_short_long_press #(
    parameter int NUM_KEYS = kdsl_pkg::NUM_KEYS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [1:0] operation, [5:2] pin_levels, [13:6] key_index, [15:14] zero
    input  logic [kdsl_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] query_hit, [4:1] short_pending, [8:5] long_pending, [15:9] zero
    output logic [kdsl_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [kdsl_pkg::APB_AW-1:0]      paddr,
    input  logic [kdsl_pkg::APB_DW-1:0]      pwdata,
    output logic [kdsl_pkg::APB_DW-1:0]      prdata,
    output logic                             pready
);
    import kdsl_pkg::*;

    t_cfg             cfg;
    logic             r_in_vld;
    logic [OP_W-1:0]  r_in_op;
    logic [PIN_W-1:0] r_in_pins;
    logic [IDX_W-1:0] r_in_idx;
    logic             r_out_vld;
    logic             r_hit, n_hit;
    logic [PIN_W-1:0] r_sp, n_sp;
    logic [PIN_W-1:0] r_lp, n_lp;
    logic             advance;
    logic             is_tick, is_qshort, is_qlong;
    t_key_ctrl        ctrl [NUM_KEYS];
    t_key_stat        stat [NUM_KEYS];
    logic [NUM_KEYS-1:0] hit_vec;

    kdsl_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign advance       = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op   <= s_axis_tdata[1:0];
            r_in_pins <= s_axis_tdata[5:2];
            r_in_idx  <= s_axis_tdata[13:6];
        end
    end

    assign is_tick   = advance && (r_in_op == OP_TICK);
    assign is_qshort = advance && (r_in_op == OP_QSHORT);
    assign is_qlong  = advance && (r_in_op == OP_QLONG);

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
        logic sel;
        logic down;

        if (k < PIN_W) begin : g_pin
            assign down = !r_in_pins[k];
        end else begin : g_nopin
            // no pin: always released
            assign down = 1'b0;
        end

        assign sel = (r_in_idx == IDX_W'(k));
        assign ctrl[k].step      = is_tick;
        assign ctrl[k].down      = down;
        assign ctrl[k].clr_short = is_qshort && sel && stat[k].short_flag;
        assign ctrl[k].clr_long  = is_qlong && sel && stat[k].long_flag;
        assign hit_vec[k]        = ctrl[k].clr_short || ctrl[k].clr_long;

        kdsl_key_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (cfg),
            .i_ctrl  (ctrl[k]),
            .o_stat  (stat[k])
        );
    end

    assign n_hit = |hit_vec;

    // show only keys that have a pin
    for (genvar k = 0; k < PIN_W; k++) begin : g_pend
        if (k < NUM_KEYS) begin : g_on
            assign n_sp[k] = stat[k].nxt_short;
            assign n_lp[k] = stat[k].nxt_long;
        end else begin : g_off
            assign n_sp[k] = 1'b0;
            assign n_lp[k] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_hit <= n_hit;
            r_sp  <= n_sp;
            r_lp  <= n_lp;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {(OUT_TDATA_W - 1 - 2 * PIN_W)'(0), r_lp, r_sp, r_hit};

endmodule

FILE: rtl/core/kdsl_checker.sv
// Port-level checker for key_debounce_short_long_press, bound to the top level.
// Depends on kdsl_pkg and key_debounce_short_long_press_assert.svh.
`include "key_debounce_short_long_press_assert.svh"

module kdsl_checker #(
    parameter int NUM_KEYS = kdsl_pkg::NUM_KEYS_DEF
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [kdsl_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [kdsl_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite,
    input logic [kdsl_pkg::APB_AW-1:0]      paddr,
    input logic [kdsl_pkg::APB_DW-1:0]      pwdata,
    input logic [kdsl_pkg::APB_DW-1:0]      prdata,
    input logic                             pready
);
    import kdsl_pkg::*;

    // keys that do not exist never show a pending flag
    localparam logic [PIN_W-1:0] ABSENT_MASK = PIN_W'(4'hF << NUM_KEYS);

    logic out_stall;
    logic absent_clear;
    logic pad_clear;

    assign out_stall    = m_axis_tvalid && !m_axis_tready;
    assign absent_clear = ((m_axis_tdata[4:1] & ABSENT_MASK) == '0) &&
                          ((m_axis_tdata[8:5] & ABSENT_MASK) == '0);
    assign pad_clear    = (m_axis_tdata[OUT_TDATA_W-1:9] == '0);

    `KDSL_ASSERT_NXT_ALWAYS(a_empty_after_reset, i_clk, !i_rst_n, !m_axis_tvalid)
    `KDSL_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
    `KDSL_ASSERT_IMP(a_absent_keys, i_clk, i_rst_n, m_axis_tvalid, absent_clear)
    `KDSL_ASSERT_IMP(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid, pad_clear && pready)

endmodule

bind key_debounce_short_long_press kdsl_checker #(.NUM_KEYS(NUM_KEYS)) u_kdsl_checker (.*);
